// ===== src/plist_pkg.sv =====
// Shared types and constants for the positional list store.
package plist_pkg;

    localparam int CMD_W = 3;
    localparam int VAL_W = 32;
    localparam int POS_W = 8;
    localparam int ST_W  = 2;
    localparam int LEN_W = 5;

    // Stream beat widths, padded to whole bytes
    localparam int IN_W    = 48;
    localparam int OUT_W   = 40;
    localparam int IN_PAD  = IN_W - CMD_W - VAL_W - POS_W;
    localparam int OUT_PAD = OUT_W - ST_W - VAL_W - LEN_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FIRST = 3'd0,
        CMD_INS_LAST  = 3'd1,
        CMD_INS_AT    = 3'd2,
        CMD_DEL_FIRST = 3'd3,
        CMD_DEL_LAST  = 3'd4,
        CMD_DEL_AT    = 3'd5,
        CMD_DUMP      = 3'd6
    } cmd_code_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    // Controller -> datapath
    typedef struct packed {
        logic capture;   // latch the input beat
        logic decode;    // latch status, target index, pointer, move count
        logic read;      // read store at pointer, step pointer
        logic copy;      // the read data is written back one slot over
        logic fin;       // write inserted value, update count
        logic out_load;  // load the result register
        logic out_dump;  // result carries an element from the store
    } ctrl_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic dec_ok;
        logic dec_dump;
        logic rem_zero;
        logic slot_free;
        logic dump_last;
    } ctrl_sts_t;

endpackage

// ===== src/plist_ctrl.sv =====
// Sequencing state machine for the positional list store.
module plist_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  plist_pkg::ctrl_sts_t  sts,
    output plist_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_SHIFT  = 7'b0000100,
        S_FIN    = 7'b0001000,
        S_RESP   = 7'b0010000,
        S_PRIME  = 7'b0100000,
        S_DUMP   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                if (!sts.dec_ok)
                begin
                    state_next = S_RESP;
                end
                else if (sts.dec_dump)
                begin
                    state_next = S_PRIME;
                end
                else
                begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                // one entry moved per cycle; last pending write lands on exit
                if (!sts.rem_zero)
                begin
                    cmd.read = 1'b1;
                    cmd.copy = 1'b1;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (sts.slot_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_PRIME:
            begin
                cmd.read   = 1'b1;
                state_next = S_DUMP;
            end
            S_DUMP:
            begin
                if (sts.slot_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_dump = 1'b1;
                    if (sts.dump_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.read = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/plist_dp.sv =====
// Datapath: element store, count, decode, move pipeline and result register.
module plist_dp
#(
    parameter int CAPACITY = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [plist_pkg::IN_W-1:0]    in_data,
    input  plist_pkg::ctrl_cmd_t          cmd,
    output plist_pkg::ctrl_sts_t          sts,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [plist_pkg::OUT_W-1:0]   out_data,
    output logic                          out_last
);

    localparam int CMD_W = plist_pkg::CMD_W;
    localparam int VAL_W = plist_pkg::VAL_W;
    localparam int POS_W = plist_pkg::POS_W;
    localparam int ST_W  = plist_pkg::ST_W;
    localparam int LEN_W = plist_pkg::LEN_W;
    localparam int PW    = $clog2(CAPACITY + 1);
    localparam int AW    = $clog2(CAPACITY);
    localparam int EW    = ((PW > POS_W) ? PW : POS_W) + 1;

    // Latched command beat
    logic [CMD_W-1:0]        cmd_reg;
    logic signed [VAL_W-1:0] val_reg;
    logic [POS_W-1:0]        pos_reg;

    // Control state
    logic [PW-1:0]           cnt_reg;
    logic [PW-1:0]           ptr_reg;
    logic [PW-1:0]           rem_reg;
    logic                    wv_reg;

    // Operation payload
    plist_pkg::status_t      status_reg;
    logic [PW-1:0]           tgt_reg;
    logic                    down_reg;
    logic [AW-1:0]           wa_reg;
    logic [VAL_W-1:0]        rd_q_reg;
    logic [VAL_W-1:0]        mem [0:CAPACITY-1];

    // Result register
    logic                    out_valid_reg;
    logic [ST_W-1:0]         out_status_reg;
    logic [VAL_W-1:0]        out_elem_reg;
    logic [LEN_W-1:0]        out_len_reg;
    logic                    out_last_reg;

    // Decode
    plist_pkg::status_t      dec_status;
    logic [PW-1:0]           dec_idx;
    logic [PW-1:0]           dec_ptr;
    logic [PW-1:0]           dec_rem;
    logic                    dec_down;
    logic [EW-1:0]           pos_x;
    logic [EW-1:0]           cnt_x;
    logic [PW-1:0]           pos_m1;
    logic                    is_ins;
    logic [AW-1:0]           ptr_a;
    logic                    slot_free;

    assign pos_x  = EW'(pos_reg);
    assign cnt_x  = EW'(cnt_reg);
    assign pos_m1 = PW'(pos_x - EW'(1));
    assign ptr_a  = ptr_reg[AW-1:0];
    assign is_ins = (cmd_reg == plist_pkg::CMD_INS_FIRST)
                 || (cmd_reg == plist_pkg::CMD_INS_LAST)
                 || (cmd_reg == plist_pkg::CMD_INS_AT);

    always_comb
    begin
        dec_status = plist_pkg::ST_OK;
        dec_idx    = '0;
        dec_ptr    = '0;
        dec_rem    = '0;
        dec_down   = 1'b0;
        case (cmd_reg)
            plist_pkg::CMD_INS_FIRST, plist_pkg::CMD_INS_LAST, plist_pkg::CMD_INS_AT:
            begin
                // full wins over a bad position
                if (cnt_reg == PW'(CAPACITY))
                begin
                    dec_status = plist_pkg::ST_FULL;
                end
                else if (cmd_reg == plist_pkg::CMD_INS_LAST)
                begin
                    dec_idx = cnt_reg;
                end
                else if (cmd_reg == plist_pkg::CMD_INS_AT)
                begin
                    if (pos_x == '0 || pos_x > cnt_x + EW'(1))
                    begin
                        dec_status = plist_pkg::ST_BADPOS;
                    end
                    else
                    begin
                        dec_idx = pos_m1;
                    end
                end
                // tail moves up one slot, walking down from the last entry
                dec_down = 1'b1;
                dec_ptr  = cnt_reg - PW'(1);
                dec_rem  = cnt_reg - dec_idx;
            end
            plist_pkg::CMD_DEL_FIRST, plist_pkg::CMD_DEL_LAST, plist_pkg::CMD_DEL_AT:
            begin
                if (cnt_reg == '0)
                begin
                    dec_status = plist_pkg::ST_EMPTY;
                end
                else if (cmd_reg == plist_pkg::CMD_DEL_LAST)
                begin
                    dec_idx = cnt_reg - PW'(1);
                end
                else if (cmd_reg == plist_pkg::CMD_DEL_AT)
                begin
                    if (pos_x == '0 || pos_x > cnt_x)
                    begin
                        dec_status = plist_pkg::ST_BADPOS;
                    end
                    else
                    begin
                        dec_idx = pos_m1;
                    end
                end
                // tail moves down one slot, walking up past the removed entry
                dec_ptr = dec_idx + PW'(1);
                dec_rem = cnt_reg - PW'(1) - dec_idx;
            end
            plist_pkg::CMD_DUMP:
            begin
                if (cnt_reg == '0)
                begin
                    dec_status = plist_pkg::ST_EMPTY;
                end
                dec_rem = cnt_reg;
            end
            default:
            begin
                dec_status = plist_pkg::ST_BADPOS;
            end
        endcase
    end

    assign slot_free     = !out_valid_reg || out_ready;
    assign sts.dec_ok    = (dec_status == plist_pkg::ST_OK);
    assign sts.dec_dump  = (cmd_reg == plist_pkg::CMD_DUMP);
    assign sts.rem_zero  = (rem_reg == '0);
    assign sts.slot_free = slot_free;
    assign sts.dump_last = (ptr_reg == cnt_reg);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            ptr_reg       <= '0;
            rem_reg       <= '0;
            wv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.fin)
            begin
                cnt_reg <= is_ins ? cnt_reg + PW'(1) : cnt_reg - PW'(1);
            end
            if (cmd.decode)
            begin
                ptr_reg <= dec_ptr;
                rem_reg <= dec_rem;
            end
            else if (cmd.read)
            begin
                ptr_reg <= down_reg ? ptr_reg - PW'(1) : ptr_reg + PW'(1);
                rem_reg <= rem_reg - PW'(1);
            end
            wv_reg <= cmd.copy;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg <= in_data[CMD_W-1:0];
            val_reg <= in_data[CMD_W +: VAL_W];
            pos_reg <= in_data[CMD_W + VAL_W +: POS_W];
        end
        if (cmd.decode)
        begin
            status_reg <= dec_status;
            tgt_reg    <= dec_idx;
            down_reg   <= dec_down;
        end
        if (cmd.copy)
        begin
            wa_reg <= down_reg ? ptr_a + AW'(1) : ptr_a - AW'(1);
        end
        if (cmd.out_load)
        begin
            out_status_reg <= cmd.out_dump ? plist_pkg::ST_OK : status_reg;
            out_elem_reg   <= cmd.out_dump ? rd_q_reg : '0;
            out_last_reg   <= cmd.out_dump ? sts.dump_last : 1'b1;
            out_len_reg    <= LEN_W'(cnt_reg);
        end
    end

    // Element store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wv_reg)
        begin
            mem[wa_reg] <= rd_q_reg;
        end
        else if (cmd.fin && is_ins)
        begin
            mem[tgt_reg[AW-1:0]] <= val_reg;
        end
        if (cmd.read)
        begin
            rd_q_reg <= mem[ptr_a];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_last  = out_last_reg;
    assign out_data  = {{plist_pkg::OUT_PAD{1'b0}}, out_len_reg, out_elem_reg, out_status_reg};

endmodule

// ===== src/positional_list_store.sv =====
// Top level of the positional list store: controller, datapath and checks.
//
//  channel  dir  tdata fields (low bit up)                  tlast
//  s_axis   in   command[2:0] value[34:3] position[42:35]   -
//  m_axis   out  status[1:0] element[33:2] length[38:34]    final_item
//
// One command at a time. An insert or delete moves the entries behind its
// position (the store has one write and one read port, so one entry moves
// per cycle); a rejected command moves none, and a dump sends one beat per
// cycle while m_axis accepts.
// The result register lets the next command be taken while a beat waits.
// Reset clears the count; store contents are undefined until written.
// A stalled m_axis beat holds the dump or the final response in place.
module positional_list_store
#(
    parameter int CAPACITY = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // command[2:0], value[34:3], position[42:35], zero pad
    input  logic [plist_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // status[1:0], element[33:2], length[38:34], zero pad
    output logic [plist_pkg::OUT_W-1:0]   m_axis_tdata,
    output logic                          m_axis_tlast
);

    plist_pkg::ctrl_cmd_t cmd;
    plist_pkg::ctrl_sts_t sts;

    plist_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    plist_dp
    #(
        .CAPACITY (CAPACITY)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

`ifndef NO_ASSERTIONS
    a_decode_follows_capture: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.capture |=> cmd.decode
    ) else $error("decode did not follow an accepted beat");

    a_copy_has_work: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.copy |-> !sts.rem_zero
    ) else $error("entry move issued with none left");

    a_no_result_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.slot_free
    ) else $error("result register overwritten while held");

    a_capture_alone: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.capture |-> !(cmd.read || cmd.out_load || cmd.fin)
    ) else $error("beat accepted while a command is in flight");
`endif

endmodule

// ===== tb/positional_list_store_tb.sv =====
// Self-checking testbench: random and directed list commands against a behavioral list model.
`timescale 1ns / 100ps

module positional_list_store_tb;

    localparam int CMD_W  = plist_pkg::CMD_W;
    localparam int VAL_W  = plist_pkg::VAL_W;
    localparam int POS_W  = plist_pkg::POS_W;
    localparam int ST_W   = plist_pkg::ST_W;
    localparam int LEN_W  = plist_pkg::LEN_W;
    localparam int IN_W   = plist_pkg::IN_W;
    localparam int OUT_W  = plist_pkg::OUT_W;
    localparam int IN_PAD = plist_pkg::IN_PAD;

    localparam int CAPACITY = 16;
    localparam int LIMIT    = 400000;
    localparam int N_DIRECTED = 25;
    localparam int N_RANDOM   = 250;
    localparam logic [CMD_W-1:0] CMD_RESERVED = 3'd7;

    typedef enum int {PH_GROW, PH_SHRINK, PH_MIXED, PH_FILL, PH_DRAIN} phase_t;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [VAL_W-1:0] val;
        logic [POS_W-1:0] pos;
        int               nres;
        bit               calm;
    } list_cmd_t;

    typedef struct {
        plist_pkg::status_t st;
        logic [VAL_W-1:0]   elem;
        logic [LEN_W-1:0]   len;
        logic               fin;
    } list_resp_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_W-1:0]    m_axis_tdata;
    logic                m_axis_tlast;

    // list model state
    logic [VAL_W-1:0]    list_mem [CAPACITY];
    int                  list_len = 0;

    list_cmd_t           pending_cmds [$];  // generated, not yet on the bus
    list_resp_t          held_resp [$];     // predicted, command not yet accepted
    list_resp_t          due_resp [$];      // command accepted, response due
    int                  drv_nres = 0;
    bit                  calm = 1'b0;
    int                  gen_count = 0;
    int                  err_cnt = 0;
    int                  cycle_cnt = 0;

    positional_list_store #(.CAPACITY(CAPACITY)) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Applies one command to the list model and stages its responses.
    task automatic list_apply(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] val,
                              input logic [POS_W-1:0] pos, output int nres);
        plist_pkg::status_t st;
        int                 idx;
        list_resp_t         r;
        st   = plist_pkg::ST_OK;
        nres = 1;
        case (cmd)
            plist_pkg::CMD_INS_FIRST, plist_pkg::CMD_INS_LAST, plist_pkg::CMD_INS_AT:
            begin
                if (list_len >= CAPACITY)
                    st = plist_pkg::ST_FULL;
                else if (cmd == plist_pkg::CMD_INS_AT && (pos < 1 || pos > list_len + 1))
                    st = plist_pkg::ST_BADPOS;
                else
                begin
                    if (cmd == plist_pkg::CMD_INS_FIRST)
                        idx = 0;
                    else if (cmd == plist_pkg::CMD_INS_LAST)
                        idx = list_len;
                    else
                        idx = int'(pos) - 1;
                    for (int i = list_len; i > idx; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[idx] = val;
                    list_len++;
                end
            end
            plist_pkg::CMD_DEL_FIRST, plist_pkg::CMD_DEL_LAST, plist_pkg::CMD_DEL_AT:
            begin
                if (list_len == 0)
                    st = plist_pkg::ST_EMPTY;
                else if (cmd == plist_pkg::CMD_DEL_AT && (pos < 1 || pos > list_len))
                    st = plist_pkg::ST_BADPOS;
                else
                begin
                    if (cmd == plist_pkg::CMD_DEL_FIRST)
                        idx = 0;
                    else if (cmd == plist_pkg::CMD_DEL_LAST)
                        idx = list_len - 1;
                    else
                        idx = int'(pos) - 1;
                    for (int i = idx; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            plist_pkg::CMD_DUMP:
            begin
                if (list_len == 0)
                    st = plist_pkg::ST_EMPTY;
            end
            default:
                st = plist_pkg::ST_BADPOS;
        endcase

        if (cmd == plist_pkg::CMD_DUMP && list_len > 0)
        begin
            for (int i = 0; i < list_len; i++)
            begin
                r.st   = plist_pkg::ST_OK;
                r.elem = list_mem[i];
                r.len  = LEN_W'(list_len);
                r.fin  = (i == list_len - 1);
                held_resp.push_back(r);
            end
            nres = list_len;
        end
        else
        begin
            r.st   = st;
            r.elem = '0;
            r.len  = LEN_W'(list_len);
            r.fin  = 1'b1;
            held_resp.push_back(r);
        end
    endtask

    task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] val,
                             input logic [POS_W-1:0] pos);
        list_cmd_t c;
        c.cmd  = cmd;
        c.val  = val;
        c.pos  = pos;
        c.calm = (gen_count >= 130 && gen_count < 190);
        list_apply(cmd, val, pos, c.nres);
        pending_cmds.push_back(c);
        gen_count++;
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // well-formed insert; position is random where the command ignores it
    task automatic push_insert();
        case ($urandom_range(2))
            0: queue_cmd(plist_pkg::CMD_INS_FIRST, pick_value(), POS_W'($urandom_range(255)));
            1: queue_cmd(plist_pkg::CMD_INS_LAST, pick_value(), POS_W'($urandom_range(255)));
            default: queue_cmd(plist_pkg::CMD_INS_AT, pick_value(),
                               POS_W'($urandom_range(list_len + 1, 1)));
        endcase
    endtask

    task automatic push_delete();
        case ($urandom_range(2))
            0: queue_cmd(plist_pkg::CMD_DEL_FIRST, $urandom, POS_W'($urandom_range(255)));
            1: queue_cmd(plist_pkg::CMD_DEL_LAST, $urandom, POS_W'($urandom_range(255)));
            default: queue_cmd(plist_pkg::CMD_DEL_AT, $urandom,
                               list_len > 0 ? POS_W'($urandom_range(list_len, 1))
                                            : POS_W'($urandom_range(3)));
        endcase
    endtask

    task automatic push_noise();
        queue_cmd(CMD_W'($urandom_range(7)), pick_value(), POS_W'($urandom_range(255)));
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || s_axis_tvalid || due_resp.size() != 0)
            @(posedge clk);
    endtask

    // command driver
    always @(posedge clk or negedge rst_n)
    begin : cmd_driver
        list_cmd_t nxt;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                for (int i = 0; i < drv_nres; i++)
                    due_resp.push_back(held_resp.pop_front());
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_cmds.size() > 0 && (calm || $urandom_range(99) >= 23))
                begin
                    nxt = pending_cmds.pop_front();
                    drv_nres      <= nxt.nres;
                    calm          <= nxt.calm;
                    s_axis_tdata  <= {{IN_PAD{1'b0}}, nxt.pos, nxt.val, nxt.cmd};
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // response monitor
    always @(posedge clk or negedge rst_n)
    begin : resp_monitor
        list_resp_t       want;
        logic [ST_W-1:0]  got_st;
        logic [VAL_W-1:0] got_el;
        logic [LEN_W-1:0] got_len;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_st  = m_axis_tdata[ST_W-1:0];
                got_el  = m_axis_tdata[ST_W+VAL_W-1:ST_W];
                got_len = m_axis_tdata[ST_W+VAL_W+LEN_W-1:ST_W+VAL_W];
                if (due_resp.size() == 0)
                begin
                    $display("%0t: unexpected beat: expected none, actual data %h last %b",
                             $time, m_axis_tdata, m_axis_tlast);
                    err_cnt++;
                end
                else
                begin
                    want = due_resp.pop_front();
                    if (got_st !== want.st)
                    begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.st, got_st);
                        err_cnt++;
                    end
                    if (got_el !== want.elem)
                    begin
                        $display("%0t: element mismatch: expected %h, actual %h",
                                 $time, want.elem, got_el);
                        err_cnt++;
                    end
                    if (got_len !== want.len)
                    begin
                        $display("%0t: length mismatch: expected %0d, actual %0d",
                                 $time, want.len, got_len);
                        err_cnt++;
                    end
                    if (m_axis_tlast !== want.fin)
                    begin
                        $display("%0t: final_item mismatch: expected %b, actual %b",
                                 $time, want.fin, m_axis_tlast);
                        err_cnt++;
                    end
                end
            end
            m_axis_tready <= calm || ($urandom_range(99) >= 23);
        end
    end

    initial
    begin
        phase_t ph;
        int     span;
        int     r;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty-list cases, extremes, bad positions, middle moves
        queue_cmd(plist_pkg::CMD_DUMP, 32'h0, 8'd0);
        queue_cmd(plist_pkg::CMD_DEL_FIRST, 32'h0, 8'd0);
        queue_cmd(plist_pkg::CMD_DEL_LAST, 32'h0, 8'd0);
        queue_cmd(plist_pkg::CMD_DEL_AT, 32'h0, 8'd3);           // empty wins over bad position
        queue_cmd(plist_pkg::CMD_INS_AT, 32'h1234_5678, 8'd2);
        queue_cmd(plist_pkg::CMD_INS_AT, 32'h8000_0000, 8'd1);   // empty list, acts as insert first
        queue_cmd(plist_pkg::CMD_INS_FIRST, 32'h7FFF_FFFF, 8'd0);
        queue_cmd(plist_pkg::CMD_INS_LAST, 32'h0000_0000, 8'd255);
        queue_cmd(plist_pkg::CMD_INS_LAST, 32'hFFFF_FFFF, 8'd0);
        queue_cmd(plist_pkg::CMD_INS_AT, 32'h1111_1111, 8'd0);
        queue_cmd(plist_pkg::CMD_INS_AT, 32'h2222_2222, 8'd6);
        queue_cmd(plist_pkg::CMD_INS_AT, 32'h3333_3333, 8'd255);
        queue_cmd(plist_pkg::CMD_INS_AT, 32'h5A5A_5A5A, 8'd3);
        queue_cmd(plist_pkg::CMD_INS_AT, 32'hA5A5_A5A5, 8'd6);   // append through count+1
        queue_cmd(plist_pkg::CMD_DUMP, 32'hFFFF_FFFF, 8'd255);
        queue_cmd(plist_pkg::CMD_DEL_AT, 32'h0, 8'd0);
        queue_cmd(plist_pkg::CMD_DEL_AT, 32'h0, 8'd7);
        queue_cmd(plist_pkg::CMD_DEL_AT, 32'h0, 8'd255);
        queue_cmd(plist_pkg::CMD_DEL_AT, 32'h0, 8'd3);
        queue_cmd(plist_pkg::CMD_DEL_AT, 32'h0, 8'd1);
        queue_cmd(plist_pkg::CMD_DEL_AT, 32'h0, 8'd4);
        queue_cmd(plist_pkg::CMD_DEL_FIRST, 32'h0, 8'd0);
        queue_cmd(plist_pkg::CMD_DEL_LAST, 32'h0, 8'd0);
        queue_cmd(CMD_RESERVED, 32'hFFFF_FFFF, 8'd1);
        queue_cmd(plist_pkg::CMD_DUMP, 32'h0, 8'd0);

        // hold off until the block has answered everything
        wait_drained();

        ph = PH_FILL;
        while (gen_count < N_DIRECTED + N_RANDOM)
        begin
            case (ph)
                PH_FILL:
                begin
                    while (list_len < CAPACITY)
                        push_insert();
                    queue_cmd(plist_pkg::CMD_INS_FIRST, pick_value(),
                              POS_W'($urandom_range(255)));
                    queue_cmd(plist_pkg::CMD_INS_LAST, pick_value(),
                              POS_W'($urandom_range(255)));
                    queue_cmd(plist_pkg::CMD_INS_AT, pick_value(),
                              POS_W'($urandom_range(255))); // full wins
                    queue_cmd(plist_pkg::CMD_DUMP, $urandom, POS_W'($urandom_range(255)));
                end
                PH_DRAIN:
                begin
                    while (list_len > 0)
                        push_delete();
                    queue_cmd(plist_pkg::CMD_DEL_AT, $urandom, POS_W'($urandom_range(255)));
                    queue_cmd(plist_pkg::CMD_DEL_LAST, $urandom, POS_W'($urandom_range(255)));
                    queue_cmd(plist_pkg::CMD_DUMP, $urandom, POS_W'($urandom_range(255)));
                end
                default:
                begin
                    span = $urandom_range(30, 10);
                    repeat (span)
                    begin
                        r = $urandom_range(99);
                        if (r < 10)
                            queue_cmd(plist_pkg::CMD_DUMP, $urandom,
                                      POS_W'($urandom_range(255)));
                        else if (r < 20)
                            push_noise();
                        else if (ph == PH_GROW)
                            if (r < 75) push_insert(); else push_delete();
                        else if (ph == PH_SHRINK)
                            if (r < 75) push_delete(); else push_insert();
                        else
                            if (r < 60) push_insert(); else push_delete();
                    end
                end
            endcase
            if (ph == PH_FILL)
                ph = PH_DRAIN;
            else
                ph = phase_t'($urandom_range(PH_DRAIN));
        end

        wait_drained();
        repeat (CAPACITY + 20) @(posedge clk);
        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
src/plist_pkg.sv
src/plist_ctrl.sv
src/plist_dp.sv
src/positional_list_store.sv
tb/positional_list_store_tb.sv
